### design/joystick_dead_zone_scaler_macros.svh
// Assertion macros shared by the joystick dead-zone scaler.
// Needs signals named clk and rst in the scope where a macro is used.
`ifndef JOYSTICK_DEAD_ZONE_SCALER_MACROS_SVH
`define JOYSTICK_DEAD_ZONE_SCALER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JDZ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JDZ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/jdz_pkg.sv
// Shared types and constants of the joystick dead-zone scaler.
// No dependencies; every other design file except the macro header imports it.
package jdz_pkg;

  localparam int RawW       = 16;
  localparam int PosW       = 12;
  localparam int MultW      = 16;
  localparam int ProdW      = PosW + MultW;
  localparam int DeltaW     = 8;
  localparam int MagW       = DeltaW - 1;
  localparam int ScaleShift = 8;
  localparam int ThirdShift = 16;
  localparam int ThirdProdW = PosW + ThirdShift;
  localparam int DivSteps   = MultW;
  localparam int DivCntW    = $clog2(DivSteps);
  localparam int CfgIdxW    = 2;
  localparam int NumSlots   = 4;

  // Offset-binary conversion of the top bits of a raw sample.
  localparam logic [PosW-1:0]       PosSign    = {1'b1, {(PosW-1){1'b0}}};
  localparam logic [PosW-1:0]       PosMax     = {PosW{1'b1}};
  // 32768, the dividend of every gain.
  localparam logic [MultW-1:0]      ScaleNum   = {1'b1, {(MultW-1){1'b0}}};
  // Reciprocal of three in 16 fractional bits; exact for 12-bit ranges.
  localparam logic [ThirdShift-1:0] Third      = 16'd21846;
  localparam logic [MagW-1:0]       DeltaLimit = 7'd127;

  typedef logic [PosW-1:0]  pos_t;
  typedef logic [MultW-1:0] mult_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_X_MIN = 2'd0,
    REG_X_MAX = 2'd1,
    REG_Y_MIN = 2'd2,
    REG_Y_MAX = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SIDE_NONE,
    SIDE_LOW,
    SIDE_HIGH
  } side_t;

  typedef struct packed {
    logic  bad;
    pos_t  lo;
    pos_t  hi;
    pos_t  tlo;
    pos_t  thi;
    mult_t mult_lo;
    mult_t mult_hi;
  } axis_cal_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_en_t;

endpackage

### design/jdz_div.sv
// Radix-2 restoring divider that forms 32768 / divisor, one quotient bit a cycle.
// Depends on jdz_pkg.
module jdz_div import jdz_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  pos_t  divisor,
  output logic  done,
  output mult_t quot
);

  logic               active;
  logic [DivCntW-1:0] cnt;
  pos_t               rem;
  logic [PosW:0]      shifted;
  logic [PosW:0]      diff;
  logic               fits;

  // The dividend sits in the quotient register and shifts out as bits come in.
  assign shifted = {rem, quot[MultW-1]};
  assign diff    = shifted - {1'b0, divisor};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
        rem    <= '0;
        quot   <= ScaleNum;
      end else if (active) begin
        rem  <= fits ? diff[PosW-1:0] : shifted[PosW-1:0];
        quot <= {quot[MultW-2:0], fits};
        cnt  <= cnt + 1'b1;
        if (cnt == DivCntW'(DivSteps - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

### design/jdz_cal.sv
// Calibration registers and the sequencer that derives thresholds and gains.
// Depends on jdz_pkg and jdz_div.
module jdz_cal import jdz_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  pos_t               cfg_data,
  output axis_cal_t          cal_x,
  output axis_cal_t          cal_y,
  output logic               busy
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANGE,
    ST_THRESH,
    ST_LAUNCH,
    ST_WAIT
  } state_t;

  state_t                  state;
  logic [1:0]              slot;
  pos_t                    lo [2];
  pos_t                    hi [2];
  pos_t                    rng [2];
  pos_t                    half [2];
  logic [ThirdProdW-1:0]   third_prod [2];
  logic                    bad [2];
  pos_t                    tlo [2];
  pos_t                    thi [2];
  pos_t                    gap [NumSlots];
  mult_t                   mult [NumSlots];
  pos_t                    third [2];
  logic                    div_done;
  mult_t                   div_quot;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      third[a] = third_prod[a][ThirdProdW-1 -: PosW];
    end
  end

  jdz_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (state == ST_LAUNCH),
    .divisor (gap[slot]),
    .done    (div_done),
    .quot    (div_quot)
  );

  // Slots: 0 and 1 are the low and high gains of x, 2 and 3 those of y.
  always_ff @(posedge clk) begin
    if (rst) begin
      lo[0] <= '0;
      lo[1] <= '0;
      hi[0] <= PosMax;
      hi[1] <= PosMax;
      slot  <= '0;
      state <= ST_RANGE;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        REG_X_MIN: lo[0] <= cfg_data;
        REG_X_MAX: hi[0] <= cfg_data;
        REG_Y_MIN: lo[1] <= cfg_data;
        REG_Y_MAX: hi[1] <= cfg_data;
        default: ;
      endcase
      state <= ST_RANGE;
    end else begin
      case (state)
        ST_RANGE: begin
          for (int a = 0; a < 2; a++) begin
            rng[a]        <= hi[a] - lo[a];
            half[a]       <= pos_t'(hi[a] - lo[a]) >> 1;
            third_prod[a] <= ThirdProdW'(pos_t'(hi[a] - lo[a])) * ThirdProdW'(Third);
            bad[a]        <= lo[a] > hi[a];
          end
          state <= ST_THRESH;
        end
        ST_THRESH: begin
          for (int a = 0; a < 2; a++) begin
            tlo[a]     <= half[a] - third[a] + lo[a];
            thi[a]     <= half[a] + third[a] + lo[a];
            gap[2*a]   <= half[a] - third[a];
            gap[2*a+1] <= rng[a] - half[a] - third[a];
          end
          slot  <= '0;
          state <= ST_LAUNCH;
        end
        ST_LAUNCH: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_done) begin
            mult[slot] <= (gap[slot] == '0) ? '0 : div_quot;
            if (slot == 2'(NumSlots - 1)) begin
              state <= ST_IDLE;
            end else begin
              slot  <= slot + 1'b1;
              state <= ST_LAUNCH;
            end
          end
        end
        ST_IDLE: ;
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign busy  = (state != ST_IDLE);
  assign cal_x = '{bad: bad[0], lo: lo[0], hi: hi[0], tlo: tlo[0], thi: thi[0],
                   mult_lo: mult[0], mult_hi: mult[1]};
  assign cal_y = '{bad: bad[1], lo: lo[1], hi: hi[1], tlo: tlo[1], thi: thi[1],
                   mult_lo: mult[2], mult_hi: mult[3]};

endmodule

### design/jdz_axis.sv
// Three-stage datapath lane for one axis: classify and clamp, multiply, saturate.
// Depends on jdz_pkg; the stage enables come from the top level.
module jdz_axis import jdz_pkg::*; (
  input  logic                     clk,
  input  pipe_en_t                 en,
  input  logic                     present,
  input  logic signed [RawW-1:0]   raw,
  input  axis_cal_t                cal,
  output logic signed [DeltaW-1:0] delta
);

  pos_t              pos;
  pos_t              clamp_lo;
  pos_t              clamp_hi;
  side_t             side_c;
  pos_t              v_c;
  mult_t             mult_c;
  side_t             side1;
  pos_t              v1;
  mult_t             mult1;
  side_t             side2;
  logic [ProdW-1:0]  prod2;
  logic [MagW-1:0]   mag;

  assign pos      = present ? (raw[RawW-1 -: PosW] ^ PosSign) : '0;
  assign clamp_lo = (pos < cal.lo) ? cal.lo : pos;
  assign clamp_hi = (pos > cal.hi) ? cal.hi : pos;

  always_comb begin
    side_c = SIDE_NONE;
    v_c    = '0;
    mult_c = '0;
    if (!cal.bad) begin
      if (pos < cal.tlo) begin
        side_c = SIDE_LOW;
        v_c    = cal.tlo - clamp_lo;
        mult_c = cal.mult_lo;
      end else if (pos > cal.thi) begin
        side_c = SIDE_HIGH;
        v_c    = clamp_hi - cal.thi;
        mult_c = cal.mult_hi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      side1 <= side_c;
      v1    <= v_c;
      mult1 <= mult_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      side2 <= side1;
      prod2 <= ProdW'(v1) * ProdW'(mult1);
    end
  end

  always_comb begin
    if (prod2[ProdW-1:ScaleShift] > (ProdW - ScaleShift)'(DeltaLimit)) begin
      mag = DeltaLimit;
    end else begin
      mag = prod2[ScaleShift +: MagW];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      case (side2)
        SIDE_LOW:  delta <= DeltaW'(0 - {1'b0, mag});
        SIDE_HIGH: delta <= {1'b0, mag};
        default:   delta <= '0;
      endcase
    end
  end

endmodule

### design/joystick_dead_zone_scaler.sv
// Channel  | Dir | Payload (lowest bits first)
// s_*      | in  | tdata: raw_horizontal[15:0], raw_vertical[31:16]; tuser: stick_present
// m_*      | out | tdata: delta_horizontal[7:0], delta_vertical[15:8]
// cfg_*    | in  | index 0..3: x_minimum, x_maximum, y_minimum, y_maximum (12 bits)
//
// One item per cycle while s_tready is high; each item passes the classify, multiply and
// saturate stages, the last being the output register.
// After reset and after every configuration write the thresholds and gains are
// recomputed by a shared serial divider; s_tready stays low meanwhile.
// A stalled output holds the last stage and every full stage behind it; earlier stages keep filling empty slots.
// Top level of the joystick dead-zone scaler; depends on jdz_pkg, jdz_cal, jdz_axis
// and the assertion macro header.
`include "joystick_dead_zone_scaler_macros.svh"

module joystick_dead_zone_scaler import jdz_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [31:0]        s_tdata,   // raw_horizontal, raw_vertical
  input  logic               s_tuser,   // stick_present
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [15:0]        m_tdata,   // delta_horizontal, delta_vertical
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [PosW-1:0]    cfg_data
);

  axis_cal_t           cal_x;
  axis_cal_t           cal_y;
  logic                cal_busy;
  pipe_en_t            en;
  logic                v1;
  logic                v2;
  logic                v3;
  logic [DeltaW-1:0]   delta_h;
  logic [DeltaW-1:0]   delta_v;

  jdz_cal u_cal (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cal_x     (cal_x),
    .cal_y     (cal_y),
    .busy      (cal_busy)
  );

  // A stage loads when it is empty or its successor is loading.
  assign en.s3    = !v3 || m_tready;
  assign en.s2    = !v2 || en.s3;
  assign en.s1    = !v1 || en.s2;
  assign s_tready = en.s1 && !cal_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en.s1) begin
        v1 <= s_tvalid && s_tready;
      end
      if (en.s2) begin
        v2 <= v1;
      end
      if (en.s3) begin
        v3 <= v2;
      end
    end
  end

  jdz_axis u_axis_h (
    .clk     (clk),
    .en      (en),
    .present (s_tuser),
    .raw     (s_tdata[RawW-1:0]),
    .cal     (cal_x),
    .delta   (delta_h)
  );

  jdz_axis u_axis_v (
    .clk     (clk),
    .en      (en),
    .present (s_tuser),
    .raw     (s_tdata[2*RawW-1:RawW]),
    .cal     (cal_y),
    .delta   (delta_v)
  );

  assign m_tvalid = v3;
  assign m_tdata  = {delta_v, delta_h};

  `JDZ_ASSERT_NEXT(a_cfg_recalc, cfg_we, cal_busy && !s_tready, "config write did not start recalibration")
  `JDZ_ASSERT_NEXT(a_stage1_hold, v1 && !en.s2, v1, "blocked first stage lost its item")
  `JDZ_ASSERT_NOW(a_delta_range, m_tvalid, (m_tdata[7:0] != 8'h80) && (m_tdata[15:8] != 8'h80), "delta outside +-127")

endmodule
